// ===== rtl/dshm_pkg.sv =====
// dshm_pkg: constants, sequencer state type and mixing helpers for the
// domain seed hash mixer. No dependencies.
`default_nettype none

package dshm_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
  localparam logic [63:0] MIX_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL1  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL2  = 64'h94d049bb133111eb;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FNV_WAIT,
    ST_MIX_PREP,
    ST_MUL1_WAIT,
    ST_MUL2_WAIT,
    ST_DELIVER
  } dshm_state_t;

  // seed into upper half, add gamma, first xor-shift
  function automatic logic [63:0] mix_pre(input logic [31:0] seed_v,
                                          input logic [63:0] hash_v);
    logic [63:0] v;
    v = ({seed_v, 32'd0} ^ hash_v) + MIX_GAMMA;
    return v ^ (v >> 30);
  endfunction

  function automatic logic [31:0] fold_out(input logic [63:0] r);
    logic [63:0] m;
    m = r ^ (r >> 31);
    return m[63:32] ^ m[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dshm_mul64.sv =====
// dshm_mul64: low 64 bits of a 64x64 product, built from three passes
// through one registered 32x32 multiplier. Uses dshm_pkg.
`default_nettype none

module dshm_mul64
  import dshm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      result
);

  logic [63:0] a_q;
  logic [63:0] b_q;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [1:0]  step;
  logic        busy;
  logic [31:0] op_x;
  logic [31:0] op_y;

  // step 0: aL*bL, step 1: aL*bH, step 2: aH*bL
  always_comb begin
    op_x = (step == 2'd2) ? a_q[63:32] : a_q[31:0];
    op_y = (step == 2'd1) ? b_q[63:32] : b_q[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= b;
    end
    if (busy) begin
      prod <= op_x * op_y;
      case (step)
        2'd1:    acc <= prod;
        2'd2:    acc[63:32] <= acc[63:32] + prod[31:0];
        2'd3:    acc[63:32] <= acc[63:32] + prod[31:0];
        default: acc <= acc;
      endcase
    end
  end

  assign result = acc;

endmodule

`default_nettype wire

// ===== rtl/domain_seed_hash_mixer_top.sv =====
// domain_seed_hash_mixer_top: FNV-1a 64 over name bytes, seed mix and
// splitmix64 finish folded to 32 bits. Uses dshm_pkg and dshm_mul64.
//
//   channel   | direction | handshake                 | payload
//   ----------+-----------+---------------------------+--------------------------
//   s_axis    | in        | s_axis_tvalid/tready      | tdata=domain_byte,
//             |           |                           | tuser=has_byte, tlast=last
//   m_axis    | out       | m_axis_tvalid/tready      | tdata=derived_value
//   cfg       | in        | cfg_valid/cfg_ready       | cfg_data=seed
//
// Sequence: an item with a nonzero byte is accepted, hashed in the shared
// multiplier and written back; a skipped byte is only accepted. A last item
// then runs the finalizer (two passes of the multiplier) and delivery.
// The shared 32x32 multiplier sets the rate; input waits while it is busy.
// Reset: synchronous, clears sequencer, hash to offset basis, seed to 0.
// Stalls: a held m_axis result blocks only the next result; bytes keep
// flowing until a new finished result needs the output register.
`default_nettype none

module domain_seed_hash_mixer_top
  import dshm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // request stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] domain_byte
  input  wire logic        s_axis_tuser,   // [0] has_byte
  input  wire logic        s_axis_tlast,
  // result stream out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] derived_value
  // seed register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  dshm_state_t state;
  dshm_state_t state_next;

  logic [63:0] hash;
  logic        ended;
  logic        last_q;
  logic [31:0] seed;

  logic        mul_start;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic        mul_done;
  logic [63:0] mul_res;

  logic        in_take;
  logic        byte_live;   // byte enters the hash
  logic        byte_term;   // zero byte closes the name
  logic        out_free;

  assign in_take   = s_axis_tvalid && s_axis_tready;
  assign byte_live = s_axis_tuser && !ended && (s_axis_tdata != 8'd0);
  assign byte_term = s_axis_tuser && !ended && (s_axis_tdata == 8'd0);
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready = 1'b1;

  dshm_mul64 u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          if (byte_live)         state_next = ST_FNV_WAIT;
          else if (s_axis_tlast) state_next = ST_MIX_PREP;
        end
      end
      ST_FNV_WAIT: begin
        if (mul_done) state_next = last_q ? ST_MIX_PREP : ST_IDLE;
      end
      ST_MIX_PREP:  state_next = ST_MUL1_WAIT;
      ST_MUL1_WAIT: if (mul_done) state_next = ST_MUL2_WAIT;
      ST_MUL2_WAIT: if (mul_done) state_next = ST_DELIVER;
      ST_DELIVER:   if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: multiplier issue and input ready
  always_comb begin
    s_axis_tready = 1'b0;
    mul_start     = 1'b0;
    mul_a         = hash ^ {56'd0, s_axis_tdata};
    mul_b         = FNV_PRIME;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        mul_start     = in_take && byte_live;
      end
      ST_MIX_PREP: begin
        mul_start = 1'b1;
        mul_a     = mix_pre(seed, hash);
        mul_b     = MIX_MUL1;
      end
      ST_MUL1_WAIT: begin
        mul_start = mul_done;
        mul_a     = mul_res ^ (mul_res >> 27);
        mul_b     = MIX_MUL2;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      hash          <= FNV_BASIS;
      ended         <= 1'b0;
      last_q        <= 1'b0;
      seed          <= 32'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) seed <= cfg_data;
      // load a finished result, else drop valid once it is taken
      if (state == ST_DELIVER && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            last_q <= s_axis_tlast;
            if (byte_term) ended <= 1'b1;
          end
        end
        ST_FNV_WAIT: begin
          if (mul_done) hash <= mul_res;
        end
        ST_DELIVER: begin
          if (out_free) begin
            hash  <= FNV_BASIS;
            ended <= 1'b0;
          end
        end
        default: begin
          hash <= hash;
        end
      endcase
    end
  end

  // result payload: loaded from the finished multiplier word
  always_ff @(posedge clk) begin
    if (state == ST_DELIVER && out_free) m_axis_tdata <= fold_out(mul_res);
  end

endmodule

`default_nettype wire

// ===== rtl/dshm_checker.sv =====
// dshm_checker: port-level assertions for domain_seed_hash_mixer_top,
// bound to the top level below. Uses no package.
`default_nettype none

module dshm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a closing request moves the sequencer out of idle, so input closes next cycle
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input ready right after a closing request");

  // the finalizer cannot produce a result in the cycle after the close
  a_last_no_early: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared too early");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind domain_seed_hash_mixer_top dshm_checker u_dshm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
